FILE: rtl/core/nmea_rmc_sentence_checker_defines.svh
// Assertion macros used by the checker file of the sentence checker.
`ifndef NMEA_RMC_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_RMC_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NRMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NRMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/nrmc_pkg.sv
// Shared types, constants and a helper function of the sentence checker.
`default_nettype none
package nrmc_pkg;

   localparam int CHAR_W      = 8;
   localparam int ZONE_W      = 5;
   localparam int HOUR_W      = 5;
   localparam int MINSEC_W    = 7;
   localparam int POS_W       = 4;
   localparam int DIGIT_W     = 4;
   localparam int TIME_DIGITS = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0]  POS_HEAD_END  = 4'd7;
   localparam logic [POS_W-1:0]  POS_TIME_END  = 4'd12;
   localparam logic [POS_W-1:0]  POS_STATUS    = 4'd13;
   localparam logic [POS_W-1:0]  POS_MAX       = 4'd15;
   localparam logic [ZONE_W-1:0] ZONE_RESET    = 5'd8;

   localparam logic [CHAR_W-1:0] CHAR_STAR     = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;

   typedef struct packed {
      logic                                accepted;
      logic [TIME_DIGITS-1:0][DIGIT_W-1:0] digits;
   } sentence_summary_type;

   // Expected header text "$GPRMC," by position.
   function automatic logic [CHAR_W-1:0] head_char(input logic [2:0] idx);
      logic [CHAR_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h52;
         3'd4:    ch = 8'h4D;
         3'd5:    ch = 8'h43;
         3'd6:    ch = 8'h2C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nrmc_req_if.sv
// Character channel: one character and its end-of-sentence flag per beat.
`default_nettype none
interface nrmc_req_if
   import nrmc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              sentence_end;

   modport source (output valid, output char_in, output sentence_end, input ready);
   modport sink   (input valid, input char_in, input sentence_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/nrmc_rsp_if.sv
// Result channel: one sentence verdict and the latched time per beat.
`default_nettype none
interface nrmc_rsp_if
   import nrmc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                sentence_accepted;
   logic                time_valid;
   logic [HOUR_W-1:0]   hour_local;
   logic [MINSEC_W-1:0] minute_val;
   logic [MINSEC_W-1:0] second_val;

   modport source (output valid, output sentence_accepted, output time_valid,
                   output hour_local, output minute_val, output second_val,
                   input ready);
   modport sink   (input valid, input sentence_accepted, input time_valid,
                   input hour_local, input minute_val, input second_val,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/nrmc_front.sv
// Front end: scans characters, tracks header, status, checksum and time digits.
`default_nettype none
module nrmc_front
   import nrmc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   nrmc_req_if.sink            req_ch,
   input  wire logic           queue_full,
   output logic                push_valid,
   output sentence_summary_type push_data
);

   logic [POS_W-1:0]                    pos_ff, pos_in;
   logic                                header_ok_ff, header_ok_in;
   logic [CHAR_W-1:0]                   xor_ff, xor_in;
   logic                                after_star_ff, after_star_in;
   logic [CHAR_W-1:0]                   rx_sum_ff, rx_sum_in;
   logic                                rx_bad_ff, rx_bad_in;
   logic                                status_seen_ff, status_seen_in;
   logic                                status_a_ff, status_a_in;
   logic [TIME_DIGITS-1:0][DIGIT_W-1:0] digit_ff, digit_in;

   logic              beat;
   logic [CHAR_W-1:0] ch;
   logic              is_dec;
   logic              is_hex_upper;
   logic              is_letter;
   logic [DIGIT_W-1:0] hex_val;

   assign req_ch.ready = !queue_full;
   assign beat         = req_ch.valid && !queue_full;
   assign ch           = req_ch.char_in;
   assign push_valid   = beat && req_ch.sentence_end;

   always_comb begin
      is_dec       = ch inside {[8'h30:8'h39]};
      is_hex_upper = ch inside {[8'h41:8'h46]};
      is_letter    = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      hex_val      = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
   end

   always_comb begin
      pos_in         = pos_ff;
      header_ok_in   = header_ok_ff;
      xor_in         = xor_ff;
      after_star_in  = after_star_ff;
      rx_sum_in      = rx_sum_ff;
      rx_bad_in      = rx_bad_ff;
      status_seen_in = status_seen_ff;
      status_a_in    = status_a_ff;
      digit_in       = digit_ff;
      push_data      = '0;

      if (beat) begin
         if (pos_ff < POS_HEAD_END && ch != head_char(pos_ff[2:0])) begin
            header_ok_in = 1'b0;
         end
         for (int k = 0; k < TIME_DIGITS; k++) begin
            if (pos_ff == POS_HEAD_END + POS_W'(k)) begin
               digit_in[k] = is_dec ? ch[3:0] : '0;
            end
         end
         if (pos_ff >= POS_STATUS && !status_seen_ff && is_letter) begin
            status_seen_in = 1'b1;
            status_a_in    = (ch == CHAR_UPPER_A);
         end
         if (pos_ff != '0) begin
            if (!after_star_ff) begin
               if (ch == CHAR_STAR) begin
                  after_star_in = 1'b1;
               end else begin
                  xor_in = xor_ff ^ ch;
               end
            end else if (!(is_dec || is_hex_upper)) begin
               rx_bad_in = 1'b1;
            end else if (!rx_bad_ff) begin
               // a nonzero upper nibble would overflow one byte on the shift
               if (rx_sum_ff[7:4] != '0) begin
                  rx_bad_in = 1'b1;
               end else begin
                  rx_sum_in = {rx_sum_ff[3:0], hex_val};
               end
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 4'd1;
         end

         if (req_ch.sentence_end) begin
            push_data.accepted = header_ok_in && (pos_ff >= POS_STATUS) && status_a_in &&
                                 !rx_bad_in && (rx_sum_in == xor_in);
            push_data.digits   = digit_in;
            // drop all per-sentence state
            pos_in         = '0;
            header_ok_in   = 1'b1;
            xor_in         = '0;
            after_star_in  = 1'b0;
            rx_sum_in      = '0;
            rx_bad_in      = 1'b0;
            status_seen_in = 1'b0;
            status_a_in    = 1'b0;
            digit_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         header_ok_ff   <= 1'b1;
         xor_ff         <= '0;
         after_star_ff  <= 1'b0;
         rx_sum_ff      <= '0;
         rx_bad_ff      <= 1'b0;
         status_seen_ff <= 1'b0;
         status_a_ff    <= 1'b0;
         digit_ff       <= '0;
      end else begin
         pos_ff         <= pos_in;
         header_ok_ff   <= header_ok_in;
         xor_ff         <= xor_in;
         after_star_ff  <= after_star_in;
         rx_sum_ff      <= rx_sum_in;
         rx_bad_ff      <= rx_bad_in;
         status_seen_ff <= status_seen_in;
         status_a_ff    <= status_a_in;
         digit_ff       <= digit_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/nrmc_queue.sv
// Short queue of sentence summaries between front end and back end.
`default_nettype none
module nrmc_queue
   import nrmc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire sentence_summary_type  push_data,
   output logic                       full,
   input  wire logic                  pop,
   output sentence_summary_type       pop_data,
   output logic                       empty
);

   sentence_summary_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/nrmc_back.sv
// Back end: applies zone offset, latches accepted time, drives result beats.
`default_nettype none
module nrmc_back
   import nrmc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [ZONE_W-1:0]    csr_wr_data,
   input  wire logic                 queue_empty,
   input  wire sentence_summary_type queue_data,
   output logic                      queue_pop,
   nrmc_rsp_if.source                rsp_ch
);

   logic [ZONE_W-1:0]   zone_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accepted_ff, accepted_in;
   logic                have_time_ff, have_time_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MINSEC_W-1:0] minute_ff, minute_in;
   logic [MINSEC_W-1:0] second_ff, second_in;

   logic [8:0] hour_sum;
   logic [8:0] hour_mod;
   logic [7:0] minute_sum;
   logic [7:0] second_sum;

   function automatic logic [7:0] two_digits(input logic [DIGIT_W-1:0] tens,
                                             input logic [DIGIT_W-1:0] ones);
      logic [7:0] t;
      t = {4'b0, tens};
      return (t << 3) + (t << 1) + {4'b0, ones};
   endfunction

   assign queue_pop = !queue_empty && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      hour_sum   = {1'b0, two_digits(queue_data.digits[0], queue_data.digits[1])} +
                   {4'b0, zone_ff};
      minute_sum = two_digits(queue_data.digits[2], queue_data.digits[3]);
      second_sum = two_digits(queue_data.digits[4], queue_data.digits[5]);
      // modulo 24 by conditional subtraction of 192, 96, 48, 24
      hour_mod = hour_sum;
      if (hour_mod >= 9'd192) hour_mod = hour_mod - 9'd192;
      if (hour_mod >= 9'd96)  hour_mod = hour_mod - 9'd96;
      if (hour_mod >= 9'd48)  hour_mod = hour_mod - 9'd48;
      if (hour_mod >= 9'd24)  hour_mod = hour_mod - 9'd24;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;
      have_time_in = have_time_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (queue_pop) begin
         rsp_valid_in = 1'b1;
         accepted_in  = queue_data.accepted;
         if (queue_data.accepted) begin
            have_time_in = 1'b1;
            hour_in      = hour_mod[HOUR_W-1:0];
            minute_in    = minute_sum[MINSEC_W-1:0];
            second_in    = second_sum[MINSEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff      <= ZONE_RESET;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
         have_time_ff <= 1'b0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            zone_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
         have_time_ff <= have_time_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
      end
   end

   // latched time only moves on a pop of an accepted sentence, so it belongs to the last accepted one
   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.sentence_accepted = accepted_ff;
   assign rsp_ch.time_valid        = have_time_ff;
   assign rsp_ch.hour_local        = hour_ff;
   assign rsp_ch.minute_val        = minute_ff;
   assign rsp_ch.second_val        = second_ff;

endmodule
`default_nettype wire

FILE: rtl/core/nmea_rmc_sentence_checker.sv
// Top level of the RMC sentence checker: front end, summary queue, back end.
//
//   channel  dir  handshake        beat payload
//   req_ch   in   valid/ready      char_in[7:0], sentence_end
//   rsp_ch   out  valid/ready      sentence_accepted, time_valid, hour_local,
//                                  minute_val, second_val
//   csr_*    in   write enable     zone_offset_hours[4:0]
//
// One character per cycle while the queue is not full; each accepted character updates the registered sentence state.
// A result passes through the summary queue, then the output register, after its closing character.
// The two-entry summary queue plus the output register hold three results; with rsp
// stalled, req_ready drops once the queue is full.
// Reset is synchronous; no clearing pass, the block accepts characters right after it.
`default_nettype none
module nmea_rmc_sentence_checker
   import nrmc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   nrmc_req_if.sink               req_ch,
   nrmc_rsp_if.source             rsp_ch,
   input  wire logic              csr_wr_en,
   input  wire logic [ZONE_W-1:0] csr_wr_data
);

   logic                 push_valid;
   sentence_summary_type push_data;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 queue_pop;
   sentence_summary_type queue_data;

   nrmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   nrmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (queue_data),
      .empty      (queue_empty)
   );

   nrmc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
`default_nettype wire

FILE: rtl/core/nrmc_checker.sv
// Port-level checks of the sentence checker and their bind to the top level.
`default_nettype none
`include "nmea_rmc_sentence_checker_defines.svh"
module nrmc_checker
   import nrmc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_sentence_end,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_sentence_accepted,
   input wire logic              rsp_time_valid,
   input wire logic [HOUR_W-1:0] rsp_hour_local
);

   logic [2:0] open_ff, open_in;
   logic       end_beat;
   logic       rsp_beat;

   assign end_beat = req_valid && req_ready && req_sentence_end;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (end_beat && !rsp_beat) begin
         open_in = open_ff + 3'd1;
      end else if (rsp_beat && !end_beat) begin
         open_in = open_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `NRMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
   `NRMC_ASSERT_NOW(a_reset_idle, clock, reset, $past(reset), !rsp_valid, "rsp valid right after reset")
   `NRMC_ASSERT_NOW(a_no_extra_rsp, clock, reset, rsp_valid, open_ff != 3'd0, "rsp beat without a closed sentence")
   `NRMC_ASSERT_NOW(a_accept_time, clock, reset, rsp_valid && rsp_sentence_accepted, rsp_time_valid && (rsp_hour_local < 5'd24), "accepted sentence without a valid time")

endmodule

bind nmea_rmc_sentence_checker nrmc_checker u_nrmc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .req_sentence_end      (req_ch.sentence_end),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_sentence_accepted (rsp_ch.sentence_accepted),
   .rsp_time_valid        (rsp_ch.time_valid),
   .rsp_hour_local        (rsp_ch.hour_local)
);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the NMEA RMC sentence checker.
`timescale 1ns / 1ps

module tb;
   import nrmc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_CHARS = 80;
   localparam int RANDOM_SENTENCES = 4;
   localparam logic [7*CHAR_W-1:0] RMC_HEAD = "$GPRMC,";

   typedef enum int {
      CS_GOOD, CS_LOWER, CS_WRONG, CS_EMPTY, CS_SHORT, CS_LEADZERO, CS_OVER,
      CS_TWOSTAR, CS_NONE
   } cs_form_type;

   typedef struct packed {
      logic                accepted;
      logic                time_ok;
      logic [HOUR_W-1:0]   hour;
      logic [MINSEC_W-1:0] minute;
      logic [MINSEC_W-1:0] second;
   } rmc_verdict_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [ZONE_W-1:0] csr_wr_data;

   nrmc_req_if req_ch ();
   nrmc_rsp_if rsp_ch ();

   nmea_rmc_sentence_checker dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sentence tracker state
   logic [ZONE_W-1:0]   zone_hours;
   logic [3:0]          pos;
   bit                  hdr_ok;
   logic [7:0]          run_xor;
   bit                  past_star;
   logic [7:0]          got_sum;
   bit                  got_bad;
   bit                  letter_seen;
   bit                  letter_is_a;
   logic [3:0]          time_dig [6];
   logic [HOUR_W-1:0]   held_hour;
   logic [MINSEC_W-1:0] held_min;
   logic [MINSEC_W-1:0] held_sec;
   bit                  held_valid;

   rmc_verdict_type verdict_q [$];
   logic [7:0]      line_q [$];

   int  errors;
   int  cycle_cnt;
   int  chars_sent;
   int  sentences_sent;
   int  results_seen;
   int  accepted_seen;
   int  zone_writes;
   int  stall_left;
   bit  burst_mode;

   task automatic clear_sentence();
      pos = '0;
      hdr_ok = 1'b1;
      run_xor = '0;
      past_star = 1'b0;
      got_sum = '0;
      got_bad = 1'b0;
      letter_seen = 1'b0;
      letter_is_a = 1'b0;
      foreach (time_dig[k]) time_dig[k] = '0;
   endtask

   task automatic track_char(input logic [7:0] c, input bit last);
      int p;
      int nib;
      int sum_next;
      int hr;
      rmc_verdict_type v;
      p = pos;
      if (p < 7 && c != RMC_HEAD[8*(6-p) +: 8]) hdr_ok = 1'b0;
      if (p >= 7 && p <= 12)
         time_dig[p-7] = (c >= "0" && c <= "9") ? 4'(c - 8'h30) : 4'd0;
      if (p >= 13 && !letter_seen &&
          ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
         letter_seen = 1'b1;
         letter_is_a = (c == CHAR_UPPER_A);
      end
      if (p >= 1) begin
         if (!past_star) begin
            if (c == CHAR_STAR) past_star = 1'b1;
            else run_xor = run_xor ^ c;
         end else begin
            nib = -1;
            if (c >= "0" && c <= "9") nib = int'(c) - 48;
            else if (c >= "A" && c <= "F") nib = int'(c) - 55;
            if (nib < 0) begin
               got_bad = 1'b1;
            end else if (!got_bad) begin
               sum_next = int'(got_sum) * 16 + nib;
               if (sum_next > 255) got_bad = 1'b1;
               else got_sum = 8'(sum_next);
            end
         end
      end
      if (pos < 15) pos = pos + 4'd1;
      if (last) begin
         v.accepted = hdr_ok && p >= 13 && letter_is_a && !got_bad && got_sum == run_xor;
         if (v.accepted) begin
            hr = int'(time_dig[0]) * 10 + int'(time_dig[1]);
            held_hour = HOUR_W'((hr + int'(zone_hours)) % 24);
            held_min = MINSEC_W'(int'(time_dig[2]) * 10 + int'(time_dig[3]));
            held_sec = MINSEC_W'(int'(time_dig[4]) * 10 + int'(time_dig[5]));
            held_valid = 1'b1;
         end
         v.time_ok = held_valid;
         v.hour = held_hour;
         v.minute = held_min;
         v.second = held_sec;
         verdict_q.push_back(v);
         clear_sentence();
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic compare_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   task automatic check_verdict();
      rmc_verdict_type want;
      results_seen++;
      if (verdict_q.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual accepted=%0b",
                  $time, rsp_ch.sentence_accepted);
         errors++;
         return;
      end
      want = verdict_q.pop_front();
      if (want.accepted) accepted_seen++;
      compare_field("sentence_accepted", 8'(want.accepted), 8'(rsp_ch.sentence_accepted));
      compare_field("time_valid", 8'(want.time_ok), 8'(rsp_ch.time_valid));
      compare_field("hour_local", 8'(want.hour), 8'(rsp_ch.hour_local));
      compare_field("minute_val", 8'(want.minute), 8'(rsp_ch.minute_val));
      compare_field("second_val", 8'(want.second), 8'(rsp_ch.second_val));
   endtask

   // Result side: check each beat, then pick the next ready with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_verdict();
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!burst_mode && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d results still outstanding",
                  $time, CYCLE_LIMIT, verdict_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c, input bit last);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_in <= c;
      req_ch.sentence_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_char(c, last);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
      line_q.delete();
      sentences_sent++;
   endtask

   // Hold off the sender until every outstanding result is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_zone(input logic [ZONE_W-1:0] z);
      drain_results();
      csr_wr_data <= z;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      zone_hours = z;
      zone_writes++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
      if (n < 10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   task automatic put_checksum(input cs_form_type form);
      logic [7:0] x;
      x = '0;
      for (int i = 1; i < line_q.size(); i++) x = x ^ line_q[i];
      if (form == CS_NONE) return;
      line_q.push_back(CHAR_STAR);
      case (form)
         CS_GOOD: begin
            line_q.push_back(hex_digit(x[7:4], 0));
            line_q.push_back(hex_digit(x[3:0], 0));
         end
         CS_LOWER: begin
            line_q.push_back(hex_digit(x[7:4], 1));
            line_q.push_back(hex_digit(x[3:0], 1));
         end
         CS_WRONG: begin
            x = x ^ 8'($urandom_range(1, 255));
            line_q.push_back(hex_digit(x[7:4], 0));
            line_q.push_back(hex_digit(x[3:0], 0));
         end
         CS_SHORT: line_q.push_back(hex_digit(x[3:0], 0));
         CS_LEADZERO, CS_OVER: begin
            line_q.push_back(form == CS_OVER ? 8'h31 : 8'h30);
            line_q.push_back(hex_digit(x[7:4], 0));
            line_q.push_back(hex_digit(x[3:0], 0));
         end
         CS_TWOSTAR: begin
            line_q.push_back(hex_digit(x[7:4], 0));
            line_q.push_back(CHAR_STAR);
            line_q.push_back(hex_digit(x[3:0], 0));
         end
         default: ;
      endcase
   endtask

   // Mostly well-formed RMC body with random time, status and trailing fields
   task automatic build_rmc(input cs_form_type form);
      int n;
      string tail_chars;
      tail_chars = ",.0123456789NSEW";
      put_text("$GPRMC,");
      for (int k = 0; k < 6; k++) begin
         if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom_range(33, 126)));
         else line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end
      put_text(",");
      if ($urandom_range(0, 4) == 0) put_text("1.5,");
      case ($urandom_range(0, 19))
         0: put_text("V");
         1: put_text("a");
         2: put_text("Z");
         3: ;
         default: put_text("A");
      endcase
      n = $urandom_range(0, 6);
      repeat (n) line_q.push_back(tail_chars[$urandom_range(0, 15)]);
      put_checksum(form);
   endtask

   task automatic test_sentence_framing();
      put_text("$");
      send_line();
      put_text("$GPRMC,123519,A,4807.038,N");
      put_checksum(CS_GOOD);
      send_line();
      // no star: xor over the whole body must come out zero
      put_text("$GPRMC,f@0011A");
      send_line();
      put_text("$GPRMC,f@0011");
      send_line();
      put_text("$GPRMC,235959,V,1");
      put_checksum(CS_GOOD);
      send_line();
      put_text("$GPRMC,000000,a");
      put_checksum(CS_GOOD);
      send_line();
      put_text("$GPRMC,101010,,*A");
      send_line();
      put_text("*GPRMC,123519,A");
      put_checksum(CS_GOOD);
      send_line();
      put_text("$GPRMD,123519,A");
      put_checksum(CS_GOOD);
      send_line();
      line_q = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
      send_line();
      put_text("$GPRMC,999999,A,0123456789.012,N,98765.43,W,0.0,0.0");
      put_checksum(CS_GOOD);
      send_line();
   endtask

   task automatic test_checksum_forms();
      for (int f = CS_GOOD; f <= CS_NONE; f++) begin
         put_text("$GPRMC,082233,A,51.5,N");
         put_checksum(cs_form_type'(f));
         send_line();
      end
   endtask

   task automatic test_zone_offsets();
      logic [ZONE_W-1:0] zones [4];
      zones = '{5'd0, 5'd23, 5'd31, 5'($urandom_range(1, 22))};
      foreach (zones[i]) begin
         set_zone(zones[i]);
         put_text("$GPRMC,235900,A");
         put_checksum(CS_GOOD);
         send_line();
         build_rmc(CS_GOOD);
         send_line();
      end
   endtask

   task automatic test_random_sentences();
      int first_char;
      int count;
      int r;
      int cut;
      first_char = chars_sent;
      count = 0;
      while (chars_sent - first_char < RANDOM_CHARS || count < RANDOM_SENTENCES) begin
         if (count % 3 == 2) set_zone(5'($urandom_range(0, 31)));
         burst_mode = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            build_rmc($urandom_range(0, 99) < 80 ? CS_GOOD
                                                  : cs_form_type'($urandom_range(1, 8)));
         end else if (r < 85) begin
            build_rmc(CS_GOOD);
            if ($urandom_range(0, 1) == 0) begin
               cut = $urandom_range(1, line_q.size());
               line_q = line_q[0:cut-1];
            end else begin
               line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end else begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
         end
         send_line();
         count++;
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.char_in = '0;
      req_ch.sentence_end = 1'b0;
      rsp_ch.ready = 1'b0;
      zone_hours = ZONE_RESET;
      clear_sentence();
      held_hour = '0;
      held_min = '0;
      held_sec = '0;
      held_valid = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_sentence_framing();
      test_checksum_forms();
      test_zone_offsets();
      test_random_sentences();
      drain_results();

      $display("Sent %0d sentences (%0d characters) over %0d zone offset settings;",
               sentences_sent, chars_sent, zone_writes + 1);
      $display("checked %0d verdicts, %0d of them accepted sentences.",
               results_seen, accepted_seen);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/nrmc_pkg.sv
rtl/core/nrmc_req_if.sv
rtl/core/nrmc_rsp_if.sv
rtl/core/nrmc_front.sv
rtl/core/nrmc_queue.sv
rtl/core/nrmc_back.sv
rtl/core/nmea_rmc_sentence_checker.sv
rtl/core/nrmc_checker.sv
tb/tb.sv
